// File: src/rab_pkg.sv
// Shared types and constants for the ray segment versus box hit test.
// Used by the top level and the pipelined divider; depends on nothing.
package rab_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned T_W = FRAC_W + 1;
  localparam int unsigned DIV_BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES = FRAC_W / DIV_BITS_PER_STAGE;

  // Configuration register indexes.
  localparam logic [2:0] REG_MIN_X = 3'd0;
  localparam logic [2:0] REG_MIN_Y = 3'd1;
  localparam logic [2:0] REG_MIN_Z = 3'd2;
  localparam logic [2:0] REG_MAX_X = 3'd3;
  localparam logic [2:0] REG_MAX_Y = 3'd4;
  localparam logic [2:0] REG_MAX_Z = 3'd5;

  // Face codes of a hit.
  localparam logic [2:0] FACE_MIN_X = 3'd0;
  localparam logic [2:0] FACE_MAX_X = 3'd1;
  localparam logic [2:0] FACE_MIN_Y = 3'd2;
  localparam logic [2:0] FACE_MAX_Y = 3'd3;
  localparam logic [2:0] FACE_MIN_Z = 3'd4;
  localparam logic [2:0] FACE_MAX_Z = 3'd5;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] delta_x;
    logic signed [COORD_W-1:0] delta_y;
    logic signed [COORD_W-1:0] delta_z;
    logic [T_W-1:0]            t_limit;
  } in_item_t;

  typedef struct packed {
    logic                      hit;
    logic [T_W-1:0]            hit_t;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [2:0]                face;
  } out_item_t;

endpackage

// File: src/rab_div.sv
// Pipelined restoring divider: t = un / ud as unsigned Q1.FRAC_W.
// Depends on rab_pkg; takes one operand per cycle.
module rab_div (
  input  logic                         clk_i,
  input  logic [rab_pkg::COORD_W:0]    un_i,
  input  logic [rab_pkg::COORD_W-1:0]  ud_i,
  input  logic                         try_i,
  output logic                         ok_o,
  output logic [rab_pkg::T_W-1:0]      quo_o
);

  localparam int unsigned CW = rab_pkg::COORD_W;
  localparam int unsigned TW = rab_pkg::T_W;
  localparam int unsigned NS = rab_pkg::DIV_STAGES;
  localparam int unsigned BPS = rab_pkg::DIV_BITS_PER_STAGE;

  // One restoring step: returns the quotient bit above the new remainder.
  function automatic logic [CW:0] div_step(input logic [CW-1:0] r,
                                           input logic [CW-1:0] d);
    logic [CW:0] r2;
    logic [CW:0] diff;
    begin
      r2 = {r, 1'b0};
      diff = r2 - {1'b0, d};
      if (r2 >= {1'b0, d}) begin
        div_step = {1'b1, diff[CW-1:0]};
      end else begin
        div_step = {1'b0, r2[CW-1:0]};
      end
    end
  endfunction

  logic [CW-1:0] rem_q [NS+1];
  logic [CW-1:0] den_q [NS+1];
  logic [TW-1:0] quo_q [NS+1];
  logic          ok_q  [NS+1];

  logic          ge1, ge2;
  logic [CW:0]   sub0;

  // Integer part: the quotient may only be zero or one.
  always_comb begin
    ge1  = un_i >= {1'b0, ud_i};
    ge2  = un_i >= {ud_i, 1'b0};
    sub0 = un_i - {1'b0, ud_i};
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= ge1 ? sub0[CW-1:0] : un_i[CW-1:0];
    den_q[0] <= ud_i;
    quo_q[0] <= {{(TW-1){1'b0}}, ge1};
    ok_q[0]  <= try_i & ~ge2;
  end

  // Fraction bits, BPS per stage.
  for (genvar k = 1; k <= NS; k++) begin : g_stage
    logic [CW-1:0] rem_d;
    logic [TW-1:0] quo_d;
    logic [CW:0]   st;

    always_comb begin
      rem_d = rem_q[k-1];
      quo_d = quo_q[k-1];
      st = '0;
      for (int unsigned i = 0; i < BPS; i++) begin
        st = div_step(rem_d, den_q[k-1]);
        rem_d = st[CW-1:0];
        quo_d = {quo_d[TW-2:0], st[CW]};
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      den_q[k] <= den_q[k-1];
      quo_q[k] <= quo_d;
      ok_q[k]  <= ok_q[k-1];
    end
  end

  assign ok_o  = ok_q[NS];
  assign quo_o = quo_q[NS];

endmodule

// File: src/ray_aabb_segment_hit.sv
// Top level of the ray segment versus axis-aligned box hit test.
// Depends on rab_pkg and instantiates one rab_div per axis.
//
// One segment is taken in every cycle and busy never rises. Its result is on
// the result ports for exactly one cycle with result_valid_o high. The
// receiver cannot hold results off. The pipeline has 14 register stages: the
// input register, the setup stage and the slab divider, then one multiply,
// one compare and one output stage. The divider has its integer stage and
// then eight stages that resolve two quotient bits each. The box bounds are
// read live, so write them only while no segment is in flight.
module ray_aabb_segment_hit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  rab_pkg::in_item_t                    item_i,
  input  logic                                 cfg_we_i,
  input  logic [2:0]                           cfg_idx_i,
  input  logic [rab_pkg::COORD_W-1:0]          cfg_wdata_i,
  output logic                                 result_valid_o,
  output rab_pkg::out_item_t                   result_o
);

  localparam int unsigned CW = rab_pkg::COORD_W;
  localparam int unsigned FW = rab_pkg::FRAC_W;
  localparam int unsigned TW = rab_pkg::T_W;
  localparam int unsigned DIV_LAT = rab_pkg::DIV_STAGES + 1;
  localparam int unsigned PW = CW + TW + 1;

  typedef struct packed {
    logic [2:0][CW-1:0] s;
    logic [2:0][CW-1:0] d;
    logic [2:0][CW-1:0] plane;
    logic [2:0]         pos;
    logic [TW-1:0]      lim;
  } side_t;

  // Box bounds.
  logic [2:0][CW-1:0] box_lo_q, box_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_lo_q <= '0;
      box_hi_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rab_pkg::REG_MIN_X: box_lo_q[0] <= cfg_wdata_i;
        rab_pkg::REG_MIN_Y: box_lo_q[1] <= cfg_wdata_i;
        rab_pkg::REG_MIN_Z: box_lo_q[2] <= cfg_wdata_i;
        rab_pkg::REG_MAX_X: box_hi_q[0] <= cfg_wdata_i;
        rab_pkg::REG_MAX_Y: box_hi_q[1] <= cfg_wdata_i;
        rab_pkg::REG_MAX_Z: box_hi_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Input register.
  logic              in_v_q;
  rab_pkg::in_item_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start & ~busy) begin
      in_q <= item_i;
    end
  end

  // Setup: entering plane, numerator and divisor magnitudes per slab.
  logic [2:0][CW-1:0] in_s, in_d;
  side_t              side_d;
  logic [2:0][CW:0]   un_d;
  logic [2:0][CW-1:0] ud_d;
  logic [2:0]         try_d;

  assign in_s = {in_q.start_z, in_q.start_y, in_q.start_x};
  assign in_d = {in_q.delta_z, in_q.delta_y, in_q.delta_x};

  for (genvar a = 0; a < 3; a++) begin : g_setup
    logic [CW:0] num;
    always_comb begin
      side_d.pos[a]   = ~in_d[a][CW-1];
      side_d.plane[a] = side_d.pos[a] ? box_lo_q[a] : box_hi_q[a];
      num = {side_d.plane[a][CW-1], side_d.plane[a]} - {in_s[a][CW-1], in_s[a]};
      try_d[a] = (in_d[a] != '0) &&
                 (side_d.pos[a] ? !num[CW] : (num[CW] || num == '0));
      un_d[a] = num[CW] ? -num : num;
      ud_d[a] = in_d[a][CW-1] ? -in_d[a] : in_d[a];
    end
  end

  always_comb begin
    side_d.s = in_s;
    side_d.d = in_d;
    side_d.lim = (in_q.t_limit > TW'(1 << FW)) ? TW'(1 << FW) : in_q.t_limit;
  end

  // Side line that runs beside the dividers.
  logic               v_q    [DIV_LAT+1];
  side_t              side_q [DIV_LAT+1];
  logic [2:0][CW:0]   un_q;
  logic [2:0][CW-1:0] ud_q;
  logic [2:0]         try_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k <= DIV_LAT; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      v_q[0] <= in_v_q;
      for (int unsigned k = 1; k <= DIV_LAT; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    un_q      <= un_d;
    ud_q      <= ud_d;
    try_q     <= try_d;
    for (int unsigned k = 1; k <= DIV_LAT; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // Slab dividers.
  logic [2:0]         div_ok;
  logic [2:0][TW-1:0] div_t;

  for (genvar a = 0; a < 3; a++) begin : g_div
    rab_div u_div (
      .clk_i (clk_i),
      .un_i  (un_q[a]),
      .ud_i  (ud_q[a]),
      .try_i (try_q[a]),
      .ok_o  (div_ok[a]),
      .quo_o (div_t[a])
    );
  end

  // Multiply stage: t times the two other deltas of each slab.
  logic                 m_v_q;
  side_t                m_side_q;
  logic [2:0]           m_ok_q;
  logic [2:0][TW-1:0]   m_t_q;
  logic signed [PW-1:0] prod_q [3][2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else begin
      m_v_q <= v_q[DIV_LAT];
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_mul
    localparam int unsigned O1 = (a + 1) % 3;
    localparam int unsigned O2 = (a + 2) % 3;
    always_ff @(posedge clk_i) begin
      m_ok_q[a]    <= div_ok[a] && (div_t[a] <= side_q[DIV_LAT].lim);
      m_t_q[a]     <= div_t[a];
      prod_q[a][0] <= $signed({1'b0, div_t[a]}) * $signed(side_q[DIV_LAT].d[O1]);
      prod_q[a][1] <= $signed({1'b0, div_t[a]}) * $signed(side_q[DIV_LAT].d[O2]);
    end
  end

  always_ff @(posedge clk_i) begin
    m_side_q <= side_q[DIV_LAT];
  end

  // Compare stage: the other two coordinates must lie inside the box.
  logic                 c_v_q;
  side_t                c_side_q;
  logic [2:0]           c_hit_q;
  logic [2:0][TW-1:0]   c_t_q;
  logic [CW-1:0]        c_pt_q [3][2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else begin
      c_v_q <= m_v_q;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_cmp
    localparam int unsigned O1 = (a + 1) % 3;
    localparam int unsigned O2 = (a + 2) % 3;
    logic signed [CW+2:0] p1, p2;
    logic                 in1, in2;
    always_comb begin
      p1 = $signed({{3{m_side_q.s[O1][CW-1]}}, m_side_q.s[O1]})
         + $signed({prod_q[a][0][PW-1], prod_q[a][0][PW-1:FW]});
      p2 = $signed({{3{m_side_q.s[O2][CW-1]}}, m_side_q.s[O2]})
         + $signed({prod_q[a][1][PW-1], prod_q[a][1][PW-1:FW]});
      in1 = (p1 >= $signed({{3{box_lo_q[O1][CW-1]}}, box_lo_q[O1]})) &&
            (p1 <= $signed({{3{box_hi_q[O1][CW-1]}}, box_hi_q[O1]}));
      in2 = (p2 >= $signed({{3{box_lo_q[O2][CW-1]}}, box_lo_q[O2]})) &&
            (p2 <= $signed({{3{box_hi_q[O2][CW-1]}}, box_hi_q[O2]}));
    end
    always_ff @(posedge clk_i) begin
      c_hit_q[a]   <= m_ok_q[a] & in1 & in2;
      c_t_q[a]     <= m_t_q[a];
      c_pt_q[a][0] <= p1[CW-1:0];
      c_pt_q[a][1] <= p2[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    c_side_q <= m_side_q;
  end

  // Output stage: the first slab in X, Y, Z order that hits wins.
  rab_pkg::out_item_t res_d;

  always_comb begin
    res_d = '0;
    if (c_hit_q[0]) begin
      res_d.hit     = 1'b1;
      res_d.hit_t   = c_t_q[0];
      res_d.point_x = c_side_q.plane[0];
      res_d.point_y = c_pt_q[0][0];
      res_d.point_z = c_pt_q[0][1];
      res_d.face    = c_side_q.pos[0] ? rab_pkg::FACE_MIN_X : rab_pkg::FACE_MAX_X;
    end else if (c_hit_q[1]) begin
      res_d.hit     = 1'b1;
      res_d.hit_t   = c_t_q[1];
      res_d.point_x = c_pt_q[1][1];
      res_d.point_y = c_side_q.plane[1];
      res_d.point_z = c_pt_q[1][0];
      res_d.face    = c_side_q.pos[1] ? rab_pkg::FACE_MIN_Y : rab_pkg::FACE_MAX_Y;
    end else if (c_hit_q[2]) begin
      res_d.hit     = 1'b1;
      res_d.hit_t   = c_t_q[2];
      res_d.point_x = c_pt_q[2][0];
      res_d.point_y = c_pt_q[2][1];
      res_d.point_z = c_side_q.plane[2];
      res_d.face    = c_side_q.pos[2] ? rab_pkg::FACE_MIN_Z : rab_pkg::FACE_MAX_Z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    result_o <= res_d;
  end

endmodule
